### rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and control types for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 7;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic accept;
        logic restart;
        logic retire;
    } t_swm_ctl;

    // flags one cell hands to its younger neighbor
    typedef struct packed {
        logic keep;
        logic young;
    } t_swm_link;

endpackage

### rtl/swm_ifs.sv
// ----------------------------------------------------------------------------
// swm channel interfaces
// Valid/ready channels for samples, results and the window width register.
// ----------------------------------------------------------------------------
interface swm_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
    import swm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] window_width;

    modport source (output valid, output window_width, input ready);
    modport sink   (input valid, input window_width, output ready);
endinterface

### rtl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming maximum over the last window_width signed samples, kept as a
// monotonic candidate list in a row of cells.
//
//   channel   role     payload                   transaction
//   i_in      sink     sample, restart           one stream sample
//   o_out     source   window_max                one window maximum
//   i_cfg     sink     window_width (7 bits)     one register write
//
// one sample per cycle while i_in.ready is high; its result is registered and shown the next cycle
// the cell row compares every candidate against the new sample in parallel
// results appear only once window_width samples (0 read as 1, capped at MAX_WINDOW) arrived since a restart
// reset clears the cell valid bits and the fill count, window_width goes to 1
// i_in.ready drops while an untaken result waits and o_out.ready is low
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swm_in_if.sink    i_in,
    swm_out_if.source o_out,
    swm_cfg_if.sink   i_cfg
);
    import swm_pkg::*;

    localparam int AGE_WIDTH = $clog2(MAX_WINDOW + 1);
    localparam int WW        = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]         r_width;
    logic [AGE_WIDTH-1:0]         r_fill;
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_value;

    logic                         acc;
    t_swm_ctl                     ctl;
    logic [WW-1:0]                w_ext;
    logic [AGE_WIDTH-1:0]         w_eff;
    logic [AGE_WIDTH-1:0]         n_fill;
    logic signed [DATA_WIDTH-1:0] sel_value;

    logic signed [DATA_WIDTH-1:0] cell_value [MAX_WINDOW];
    logic        [AGE_WIDTH-1:0]  cell_age   [MAX_WINDOW];
    logic signed [DATA_WIDTH-1:0] next_value [MAX_WINDOW];
    t_swm_link                    link       [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]        cell_valid;
    logic [MAX_WINDOW-1:0]        first_vec;

    assign acc       = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        ctl.accept  = acc;
        ctl.restart = i_in.restart;
        ctl.retire  = cell_valid[0] && !i_in.restart
                      && ((AGE_WIDTH + 1)'(cell_age[0]) + (AGE_WIDTH + 1)'(1)
                          >= (AGE_WIDTH + 1)'(MAX_WINDOW));
    end

    always_comb begin
        w_ext = WW'(r_width);
        if (r_width == '0) begin
            w_eff = AGE_WIDTH'(1);
        end else if (w_ext > WW'(MAX_WINDOW)) begin
            w_eff = AGE_WIDTH'(MAX_WINDOW);
        end else begin
            w_eff = w_ext[AGE_WIDTH-1:0];
        end
    end

    always_comb begin
        if (i_in.restart) begin
            n_fill = AGE_WIDTH'(1);
        end else if (r_fill < AGE_WIDTH'(MAX_WINDOW)) begin
            n_fill = r_fill + AGE_WIDTH'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_swm_link                    left;
        logic signed [DATA_WIDTH-1:0] right_value;
        logic        [AGE_WIDTH-1:0]  right_age;
        logic                         right_valid;

        if (g == 0) begin : g_head
            assign left.keep  = 1'b1;
            assign left.young = 1'b0;
        end else begin : g_body
            assign left = link[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign right_value = '0;
            assign right_age   = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = cell_value[g+1];
            assign right_age   = cell_age[g+1];
            assign right_valid = cell_valid[g+1];
        end

        swm_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AGE_WIDTH  (AGE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_sample      (i_in.sample),
            .i_width       (w_eff),
            .i_left        (left),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .i_right_valid (right_valid),
            .o_link        (link[g]),
            .o_value       (cell_value[g]),
            .o_age         (cell_age[g]),
            .o_valid       (cell_valid[g]),
            .o_first       (first_vec[g]),
            .o_next_value  (next_value[g])
        );
    end

    // oldest candidate still inside the window
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            sel_value = sel_value | (first_vec[i] ? next_value[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CFG_WIDTH'(1);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_width <= i_cfg.window_width;
            end
            if (acc) begin
                r_fill      <= n_fill;
                r_out_valid <= (n_fill >= w_eff);
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_value <= sel_value;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_max = r_out_value;

    a_head_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> cell_valid[0])
        else $error("cell 0 empty after a transaction");

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid + MAX_WINDOW'(1)) & cell_valid) == '0)
        else $error("valid cells do not form a prefix");

    a_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> $onehot(first_vec))
        else $error("window select not one-hot");

    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.restart |=> !r_out_valid || $past(w_eff) == AGE_WIDTH'(1))
        else $error("result after restart before window filled");

    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(acc))
        else $error("result without an input transaction");

endmodule

### rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One candidate slot of the monotonic list: value, age and valid bit.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_WIDTH  = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swm_pkg::t_swm_ctl            i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  logic        [AGE_WIDTH-1:0]  i_width,
    input  swm_pkg::t_swm_link           i_left,
    input  logic signed [DATA_WIDTH-1:0] i_right_value,
    input  logic        [AGE_WIDTH-1:0]  i_right_age,
    input  logic                         i_right_valid,
    output swm_pkg::t_swm_link           o_link,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic        [AGE_WIDTH-1:0]  o_age,
    output logic                         o_valid,
    output logic                         o_first,
    output logic signed [DATA_WIDTH-1:0] o_next_value
);
    import swm_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_value;
    logic        [AGE_WIDTH-1:0]  r_age;
    logic                         r_valid;

    logic signed [DATA_WIDTH-1:0] cur_value;
    logic        [AGE_WIDTH-1:0]  cur_age;
    logic                         cur_valid;
    logic                         keep;
    logic                         insert;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic        [AGE_WIDTH-1:0]  n_age;
    logic                         n_valid;
    logic                         young;

    always_comb begin
        cur_value = i_ctl.retire ? i_right_value : r_value;
        cur_age   = i_ctl.retire ? i_right_age   : r_age;
        cur_valid = (i_ctl.retire ? i_right_valid : r_valid) && !i_ctl.restart;
        keep      = cur_valid && (cur_value >= i_sample);
        insert    = !keep && i_left.keep;
        n_valid   = keep || insert;
        n_value   = keep ? cur_value : i_sample;
        n_age     = keep ? cur_age + AGE_WIDTH'(1) : '0;
        young     = n_valid && (n_age < i_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.accept) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.keep  = keep;
    assign o_link.young = young;
    assign o_first      = young && !i_left.young;
    assign o_next_value = n_value;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_valid      = r_valid;

endmodule

### test/sliding_window_maximum_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// Drives signed samples with restarts through the sliding window maximum
// block under varied window widths and handshake pressure. A scoreboard class
// keeps its own monotonic candidate list, predicts each window maximum and
// compares every result transaction in order.
// ----------------------------------------------------------------------------
class window_max_scoreboard;
    localparam int MW    = swm_pkg::MAX_WINDOW_DEF;
    localparam int DW    = swm_pkg::DATA_WIDTH_DEF;
    localparam int CW    = swm_pkg::CFG_WIDTH;
    localparam int POS_W = $clog2(2 * MW);

    typedef struct {
        logic signed [DW-1:0] value;
        logic [POS_W-1:0]     position;
    } t_cand;

    t_cand                cands[$];
    logic signed [DW-1:0] expected_max[$];
    logic [CW-1:0]        width_reg;
    logic [POS_W-1:0]     arrivals;
    int unsigned          filled;
    int unsigned          samples;
    int unsigned          checked;
    int unsigned          restarts;
    int unsigned          aged_out;
    int unsigned          errors;

    function new();
        width_reg = CW'(1);
        arrivals  = '0;
        filled    = 0;
        samples   = 0;
        checked   = 0;
        restarts  = 0;
        aged_out  = 0;
        errors    = 0;
    endfunction

    function void set_width(logic [CW-1:0] w);
        width_reg = w;
    endfunction

    function int unsigned age(logic [POS_W-1:0] now, logic [POS_W-1:0] pos);
        logic [POS_W-1:0] d;
        d = now - pos;
        return 32'(d);
    endfunction

    function int unsigned span();
        if (width_reg == 0) return 1;
        if (width_reg > MW) return MW;
        return 32'(width_reg);
    endfunction

    function int pending();
        return expected_max.size();
    endfunction

    function void note_sample(logic signed [DW-1:0] s, logic rs);
        t_cand            c;
        logic [POS_W-1:0] now;
        int unsigned      w;
        now = arrivals;
        samples++;
        if (rs) begin
            cands.delete();
            filled = 0;
            restarts++;
        end
        if (cands.size() > 0 && age(now, cands[0].position) >= MW) begin
            cands.delete(0);
            aged_out++;
        end
        while (cands.size() > 0 && s > cands[cands.size()-1].value)
            cands.delete(cands.size() - 1);
        if (cands.size() < MW) begin
            c.value    = s;
            c.position = now;
            cands      = {cands, c};
        end
        arrivals = now + 1'b1;
        if (filled < MW) filled++;
        w = span();
        if (filled < w) return;
        foreach (cands[i]) begin
            if (age(now, cands[i].position) < w) begin
                expected_max = {expected_max, cands[i].value};
                return;
            end
        end
        expected_max = {expected_max, s};
    endfunction

    function void check_max(logic signed [DW-1:0] got);
        logic signed [DW-1:0] exp;
        if (expected_max.size() == 0) begin
            $error("window_max: no transaction expected, got %0d", got);
            errors++;
            return;
        end
        exp = expected_max[0];
        expected_max.delete(0);
        checked++;
        if (got !== exp) begin
            $error("window_max: expected %0d, got %0d", exp, got);
            errors++;
        end
    endfunction
endclass

module sliding_window_maximum_tb;
    import swm_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int LIMIT       = 200000;
    localparam int LONG_HOLD   = 60;
    localparam int PHASE_ITEMS = 40;
    localparam int RAMP_ITEMS  = 80;
    localparam logic signed [DW-1:0] MIN_S = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] MAX_S = {1'b0, {(DW-1){1'b1}}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned long_hold_reqs = 0;
    int unsigned cycle_count = 0;
    logic signed [DW-1:0] ramp_level = MAX_S;
    window_max_scoreboard sb = new();

    swm_in_if #(.DATA_WIDTH(DW)) in_ch ();
    swm_out_if #(.DATA_WIDTH(DW)) out_ch ();
    swm_cfg_if cfg_ch ();

    sliding_window_maximum i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // handshakes are stable from the falling edge to the accepting rising edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_max(out_ch.window_max);
            if (cfg_ch.valid && cfg_ch.ready) sb.set_width(cfg_ch.window_width);
            if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample, in_ch.restart);
        end
    end

    initial begin : result_sink
        int          hold_left;
        int unsigned holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_reqs != holds_taken) begin
                holds_taken = long_hold_reqs;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function void set_idling(t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    function logic signed [DW-1:0] next_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return $urandom;
        if (pick < 55) return $signed($urandom_range(8)) - 4;
        if (pick < 65) begin
            case ($urandom_range(3))
                0:       return MIN_S;
                1:       return MAX_S;
                2:       return '0;
                default: return '1;
            endcase
        end
        // descending runs build long candidate lists
        ramp_level = ramp_level - $urandom_range(3);
        if ($urandom_range(15) == 0) ramp_level = $urandom;
        return ramp_level;
    endfunction

    task automatic send_sample(input logic signed [DW-1:0] s, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= rs;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain(input int settle);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_WIDTH-1:0] w);
        drain(4);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.window_width <= w;
        @(negedge clk);
        while (!cfg_ch.ready) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        logic [CFG_WIDTH-1:0] w;
        t_idle_mode           mode;
        in_ch.valid         <= 1'b0;
        in_ch.sample        <= '0;
        in_ch.restart       <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.window_width <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: width one from reset, each sample is its own maximum
        set_idling(IDLE_NONE);
        send_sample(MAX_S, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(1, 1'b1);
        write_width(CFG_WIDTH'(0));
        send_sample(MIN_S, 1'b0);
        send_sample(MAX_S, 1'b0);
        // short stream cut by a restart, then equal samples
        write_width(CFG_WIDTH'(3));
        send_sample(10, 1'b0);
        send_sample(20, 1'b0);
        send_sample(5, 1'b1);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample(MAX_S, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(-2, 1'b0);
        send_sample(-3, 1'b0);
        // width above the list depth, then narrowed mid-stream
        write_width(CFG_WIDTH'(127));
        send_sample(7, 1'b0);
        send_sample(-7, 1'b0);
        write_width(CFG_WIDTH'(2));
        send_sample(8, 1'b0);
        send_sample(-8, 1'b0);

        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       w = CFG_WIDTH'(1);
                1:       w = CFG_WIDTH'(2);
                2:       w = CFG_WIDTH'(0);
                3:       w = CFG_WIDTH'(64);
                4:       w = CFG_WIDTH'(100);
                5:       w = CFG_WIDTH'($urandom_range(1, 16));
                6:       w = CFG_WIDTH'(127);
                7:       w = CFG_WIDTH'($urandom_range(1, 64));
                default: w = CFG_WIDTH'($urandom_range(0, 127));
            endcase
            mode = t_idle_mode'(p % 4);
            write_width(w);
            set_idling(mode);
            if (p == 6) begin
                // strictly falling ramp fills the list and ages out its head
                for (int k = 0; k < RAMP_ITEMS; k++)
                    send_sample(MAX_S - 3 * k, k == 0);
            end else begin
                for (int k = 0; k < PHASE_ITEMS; k++) begin
                    if (p == 4 && k == 10) long_hold_reqs++;
                    if (p == 5 && k == 20) drain(0);
                    send_sample(next_sample(), $urandom_range(59) == 0);
                end
            end
        end

        drain(8);
        $display("covered %0d samples with %0d restarts, %0d window maxima checked",
                 sb.samples, sb.restarts, sb.checked);
        $display("%0d candidates aged out of the list, widths 0 to 127 including saturation",
                 sb.aged_out);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
